### rtl/core/jsg_pkg.sv
// Shared types and constants for the jog step generator.
// No dependencies; imported by every module of the block.
package jsg_pkg;

   localparam int AXIS_SLOTS = 4;
   localparam int SEL_W      = 2;
   localparam int SPEED_W    = 9;
   localparam int SPM_W      = 16;
   localparam int PROD_W     = SPEED_W + SPM_W;
   localparam int LOW_W      = 30;
   localparam int PULSE_W    = 6;
   localparam int CNT_W      = 5;
   localparam int ADDR_W     = 5;
   localparam int DATA_W     = 32;
   localparam int SPD_CMP_W  = 12;

   // 3e10 ns scaled by 256 for the Q8.8 steps-per-mm value
   localparam logic [42:0]        LOW_TIME_NUM = 43'd7680000000000;
   localparam logic [LOW_W-1:0]   LOW_TIME_MAX = 30'd999999999;

   // speed / 15 as (speed * 2185) >> 15, exact for 9-bit speeds
   localparam logic [11:0]        RECIP15       = 12'd2185;
   localparam int                 RECIP15_SHIFT = 15;
   localparam logic [SPEED_W-1:0] LOW_SPEED     = 9'd16;
   localparam logic [PULSE_W-1:0] LOW_PULSES    = 6'd2;

   localparam logic REQ_JOG    = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   localparam logic [2:0] REG_SPEED = 3'd0;
   localparam logic [2:0] REG_SPM0  = 3'd1;
   localparam logic [2:0] REG_SPM1  = 3'd2;
   localparam logic [2:0] REG_SPM2  = 3'd3;
   localparam logic [2:0] REG_SPM3  = 3'd4;

   localparam logic [SPEED_W-1:0] SPEED_RESET = 9'd500;
   localparam logic [SPM_W-1:0]   SPM_RESET   = 16'd256;

   typedef enum logic [1:0] {
      LOCK_NONE = 2'd0,
      LOCK_NEG  = 2'd1,
      LOCK_POS  = 2'd2
   } lock_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MUL,
      ST_START,
      ST_WAIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [SPEED_W-1:0]                jog_speed;
      logic [AXIS_SLOTS-1:0][SPM_W-1:0]  spm;
   } cfg_type;

endpackage

### rtl/core/jsg_csr.sv
// Configuration registers behind the APB-style port: jog speed and steps per mm.
// Depends on jsg_pkg.
module jsg_csr import jsg_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] idx;
   logic       wr_en;

   assign idx        = csr_paddr[4:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_SPEED: cfg_in.jog_speed = csr_pwdata[SPEED_W-1:0];
            REG_SPM0, REG_SPM1, REG_SPM2, REG_SPM3:
               cfg_in.spm[2'(idx - REG_SPM0)] = csr_pwdata[SPM_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_SPEED: csr_prdata = DATA_W'(cfg_ff.jog_speed);
         REG_SPM0, REG_SPM1, REG_SPM2, REG_SPM3:
            csr_prdata = DATA_W'(cfg_ff.spm[2'(idx - REG_SPM0)]);
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.jog_speed <= SPEED_RESET;
         for (int a = 0; a < AXIS_SLOTS; a++) begin
            cfg_ff.spm[a] <= SPM_RESET;
         end
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/core/jsg_div.sv
// Restoring divider for the pulse low time: one quotient bit per cycle,
// saturated at LOW_TIME_MAX. Depends on jsg_pkg.
module jsg_div import jsg_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [PROD_W-1:0] divisor,
   output logic              done,
   output logic [LOW_W-1:0]  quotient
);

   localparam logic [12:0]      NUM_HI = LOW_TIME_NUM[42:30];
   localparam logic [LOW_W-1:0] NUM_LO = LOW_TIME_NUM[LOW_W-1:0];

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [PROD_W-1:0] rem_ff, rem_in;
   logic [PROD_W-1:0] dvs_ff, dvs_in;
   logic [LOW_W-1:0]  quo_ff, quo_in;
   logic [LOW_W-1:0]  res_ff, res_in;

   logic [CNT_W-1:0]  bit_idx;
   logic [PROD_W:0]   trial;
   logic [PROD_W:0]   diff;
   logic              fits;
   logic [LOW_W-1:0]  quo_next;

   assign bit_idx  = CNT_W'(LOW_W - 1) - cnt_ff;
   assign trial    = {rem_ff, NUM_LO[bit_idx]};
   assign fits     = trial >= {1'b0, dvs_ff};
   assign diff     = trial - {1'b0, dvs_ff};
   assign quo_next = {quo_ff[LOW_W-2:0], fits};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      res_in  = res_ff;
      if (start) begin
         // quotient of 2^30 or more is already past saturation
         if (PROD_W'(NUM_HI) >= divisor) begin
            res_in  = LOW_TIME_MAX;
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
            cnt_in  = '0;
            rem_in  = PROD_W'(NUM_HI);
            dvs_in  = divisor;
            quo_in  = '0;
         end
      end else if (busy_ff) begin
         rem_in = fits ? diff[PROD_W-1:0] : trial[PROD_W-1:0];
         quo_in = quo_next;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(LOW_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            res_in  = (quo_next > LOW_TIME_MAX) ? LOW_TIME_MAX : quo_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
      res_ff <= res_in;
   end

   assign done     = done_ff;
   assign quotient = res_ff;

endmodule

### rtl/core/jog_step_generator_with_limit_lockout.sv
// Jog step generator with limit lockout, top level; uses jsg_pkg, jsg_csr and jsg_div.
// From request taken to result handshake: a jog that moves takes one multiply, then 30
// steps of the single restoring divider; the divider skips its steps when the low time
// saturates at once (small product of speed and steps per mm); samples and refused jogs skip both.
// Throughput: one request at a time; the next request is taken once the result is registered.
// Reset (synchronous): all axes unlocked and negative, speed 500, steps per mm 1.0.
module jog_step_generator_with_limit_lockout import jsg_pkg::*; #(
   parameter int NUM_AXES  = 4,
   parameter int MAX_SPEED = 500
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_type,
   input  logic [SEL_W-1:0]      req_axis_sel,
   input  logic                  req_jog_dir,
   input  logic [AXIS_SLOTS-1:0] req_limit_bits,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_moved,
   output logic [PULSE_W-1:0]    rsp_pulse_count,
   output logic [LOW_W-1:0]      rsp_low_time_ns,
   output logic [2*AXIS_SLOTS-1:0] rsp_lock_states,
   output logic [AXIS_SLOTS-1:0] rsp_dir_bits,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [ADDR_W-1:0]     csr_paddr,
   input  logic [DATA_W-1:0]     csr_pwdata,
   output logic [DATA_W-1:0]     csr_prdata,
   output logic                  csr_pready
);

   cfg_type cfg;

   state_type state_ff, state_in;

   logic                  type_ff, type_in;
   logic [SEL_W-1:0]      sel_ff, sel_in;
   logic                  jdir_ff, jdir_in;
   logic [AXIS_SLOTS-1:0] lim_ff, lim_in;

   lock_type              lock_ff [AXIS_SLOTS];
   lock_type              lock_in [AXIS_SLOTS];
   logic [AXIS_SLOTS-1:0] dir_ff, dir_in;
   logic [AXIS_SLOTS-1:0] present;

   logic [SPEED_W-1:0]    speed_ff, speed_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic                  moved_ff, moved_in;
   logic [PULSE_W-1:0]    pulse_ff, pulse_in;
   logic [LOW_W-1:0]      low_ff, low_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_moved_ff;
   logic [PULSE_W-1:0]    rsp_pulse_ff;
   logic [LOW_W-1:0]      rsp_low_ff;
   logic [2*AXIS_SLOTS-1:0] rsp_lock_ff, lock_pack;
   logic [AXIS_SLOTS-1:0] rsp_dir_ff;
   logic                  rsp_load;

   logic                  div_start;
   logic                  div_done;
   logic [LOW_W-1:0]      div_quo;

   logic [SPEED_W-1:0]    speed_sat;
   logic [20:0]           recip_prod;
   lock_type              want_lock;

   jsg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   jsg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (prod_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   for (genvar a = 0; a < AXIS_SLOTS; a++) begin : g_present
      assign present[a] = (a < NUM_AXES);
   end

   assign speed_sat = ({{(SPD_CMP_W-SPEED_W){1'b0}}, cfg.jog_speed} > SPD_CMP_W'(MAX_SPEED))
                      ? SPEED_W'(MAX_SPEED) : cfg.jog_speed;
   assign recip_prod = 21'(speed_sat) * 21'(RECIP15);
   assign want_lock  = jdir_ff ? LOCK_POS : LOCK_NEG;
   assign rsp_load   = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);
   assign div_start  = (state_ff == ST_START);
   assign req_ready  = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      type_in  = type_ff;
      sel_in   = sel_ff;
      jdir_in  = jdir_ff;
      lim_in   = lim_ff;
      lock_in  = lock_ff;
      dir_in   = dir_ff;
      speed_in = speed_ff;
      prod_in  = prod_ff;
      moved_in = moved_ff;
      pulse_in = pulse_ff;
      low_in   = low_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               type_in  = req_type;
               sel_in   = req_axis_sel;
               jdir_in  = req_jog_dir;
               lim_in   = req_limit_bits;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            moved_in = 1'b0;
            pulse_in = '0;
            low_in   = '0;
            speed_in = speed_sat;
            state_in = ST_FINISH;
            if (type_ff == REQ_SAMPLE) begin
               // lock each tripped, unlocked axis in the way it is heading
               for (int a = 0; a < AXIS_SLOTS; a++) begin
                  if (present[a] && lim_ff[a] && lock_ff[a] == LOCK_NONE) begin
                     lock_in[a] = dir_ff[a] ? LOCK_POS : LOCK_NEG;
                  end
               end
            end else if (present[sel_ff] && lock_ff[sel_ff] != want_lock) begin
               dir_in[sel_ff] = jdir_ff;
               if (lock_ff[sel_ff] != LOCK_NONE && !lim_ff[sel_ff]) begin
                  lock_in[sel_ff] = LOCK_NONE;
               end
               moved_in = 1'b1;
               pulse_in = (speed_sat > LOW_SPEED)
                          ? recip_prod[RECIP15_SHIFT +: PULSE_W] + 1'b1 : LOW_PULSES;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = PROD_W'(speed_ff) * PROD_W'(cfg.spm[sel_ff]);
            state_in = ST_START;
         end
         ST_START: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_done) begin
               low_in   = div_quo;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      for (int a = 0; a < AXIS_SLOTS; a++) begin
         lock_pack[2*a +: 2] = lock_ff[a];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         dir_ff       <= '0;
         for (int a = 0; a < AXIS_SLOTS; a++) begin
            lock_ff[a] <= LOCK_NONE;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         dir_ff       <= dir_in;
         lock_ff      <= lock_in;
      end
      type_ff  <= type_in;
      sel_ff   <= sel_in;
      jdir_ff  <= jdir_in;
      lim_ff   <= lim_in;
      speed_ff <= speed_in;
      prod_ff  <= prod_in;
      moved_ff <= moved_in;
      pulse_ff <= pulse_in;
      low_ff   <= low_in;
      if (rsp_load) begin
         rsp_moved_ff <= moved_ff;
         rsp_pulse_ff <= pulse_ff;
         rsp_low_ff   <= low_ff;
         rsp_lock_ff  <= lock_pack;
         rsp_dir_ff   <= dir_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_moved       = rsp_moved_ff;
   assign rsp_pulse_count = rsp_pulse_ff;
   assign rsp_low_time_ns = rsp_low_ff;
   assign rsp_lock_states = rsp_lock_ff;
   assign rsp_dir_bits    = rsp_dir_ff;

endmodule
